// File: sv/sorted_dot_table_page_renderer_core_assert.svh
// ----------------------------------------------------------------------------
// sorted dot table assertion macros
// shared concurrent assertion forms for the dot table checker
// ----------------------------------------------------------------------------
`ifndef SORTED_DOT_TABLE_PAGE_RENDERER_CORE_ASSERT_SVH
`define SORTED_DOT_TABLE_PAGE_RENDERER_CORE_ASSERT_SVH

// condition implies property in the same cycle
`define SDTPR_ASSERT_SAME(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
    else $error("sdtpr check failed");

// condition implies property in the next cycle
`define SDTPR_ASSERT_NEXT(lbl, clk, rstn, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
    else $error("sdtpr check failed");

`endif

// File: sv/sdtpr_pkg.sv
// ----------------------------------------------------------------------------
// sdtpr_pkg
// field widths, codes and shared types of the sorted dot table renderer
// ----------------------------------------------------------------------------
package sdtpr_pkg;

  // item field widths
  localparam int unsigned OP_W        = 2;
  localparam int unsigned X_W         = 7;
  localparam int unsigned Y_W         = 4;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned ADDR_W      = 8;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_APPEND  = 2'd1,
    OP_REPLACE = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_DUP   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_DECIDE,
    S_SORT,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_LOAD,
    CELL_FROM_LEFT,
    CELL_FROM_RIGHT
  } cell_op_e;

  // operands broadcast to every cell
  typedef struct packed {
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [ADDR_W-1:0] new_addr;
    logic [ADDR_W-1:0] baddr;
  } bcast_t;

  // what one cell shows to its neighbors and to the control
  typedef struct packed {
    logic [X_W-1:0]    x;
    logic [Y_W-1:0]    y;
    logic [ADDR_W-1:0] addr;
    logic              eq;
    logic              gt_new;
    logic              hit;
    logic              gt_right;
  } cell_out_t;

  // display address: column plus one row of columns for the lower page half
  function automatic logic [ADDR_W-1:0] dot_addr(input logic [X_W-1:0] x,
                                                 input logic [Y_W-1:0] y,
                                                 input logic [ADDR_W-1:0] cols);
    dot_addr = ADDR_W'(x) + (y[Y_W-1] ? cols : '0);
  endfunction

endpackage

// File: sv/sdtpr_cell.sv
// ----------------------------------------------------------------------------
// sdtpr_cell
// one table slot: holds a dot, compares it and trades it with its neighbors
// ----------------------------------------------------------------------------
module sdtpr_cell #(
  parameter int unsigned COLUMNS = 96
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sdtpr_pkg::cell_op_e   op_i,
  input  sdtpr_pkg::bcast_t     bcast_i,
  input  sdtpr_pkg::cell_out_t  left_i,
  input  sdtpr_pkg::cell_out_t  right_i,
  output sdtpr_pkg::cell_out_t  cell_o
);

  logic [sdtpr_pkg::X_W-1:0]    x_q, x_d;
  logic [sdtpr_pkg::Y_W-1:0]    y_q, y_d;
  logic [sdtpr_pkg::ADDR_W-1:0] addr;

  // slot contents, zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      y_q <= '0;
    end else begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  // next contents by command
  always_comb begin
    x_d = x_q;
    y_d = y_q;
    case (op_i)
      sdtpr_pkg::CELL_HOLD: ;
      sdtpr_pkg::CELL_CLEAR: begin
        x_d = '0;
        y_d = '0;
      end
      sdtpr_pkg::CELL_LOAD: begin
        x_d = bcast_i.x;
        y_d = bcast_i.y;
      end
      sdtpr_pkg::CELL_FROM_LEFT: begin
        x_d = left_i.x;
        y_d = left_i.y;
      end
      sdtpr_pkg::CELL_FROM_RIGHT: begin
        x_d = right_i.x;
        y_d = right_i.y;
      end
      default: ;
    endcase
  end

  // local compares
  assign addr = sdtpr_pkg::dot_addr(x_q, y_q, sdtpr_pkg::ADDR_W'(COLUMNS));

  always_comb begin
    cell_o.x        = x_q;
    cell_o.y        = y_q;
    cell_o.addr     = addr;
    cell_o.eq       = (x_q == bcast_i.x) && (y_q == bcast_i.y);
    cell_o.gt_new   = addr > bcast_i.new_addr;
    cell_o.hit      = addr == bcast_i.baddr;
    cell_o.gt_right = addr > right_i.addr;
  end

endmodule

// File: sv/sorted_dot_table_page_renderer_core.sv
// ----------------------------------------------------------------------------
// sorted_dot_table_page_renderer_core
// sorted dot table in a row of cells with page byte rendering
// ----------------------------------------------------------------------------
// steps: idle accept, evaluate, then clear goes straight to the output state; append,
//   read and replace go through decide, and a sorting replace then runs n odd-even
//   phases, one per cycle, n = min(active_dots, MAX_DOTS), before the output state
// one item at a time: the next item is taken once the result is in the output register
// stalls: input waits while a finished result finds the output register full
// reset: asynchronous active low, clears the table, the fill count, active_dots
//   and the result valid flag
module sorted_dot_table_page_renderer_core #(
  parameter int unsigned MAX_DOTS = 40,
  parameter int unsigned COLUMNS  = 96
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration write: active_dots
  input  logic                                 cfg_we_i,
  input  logic [sdtpr_pkg::CFG_W-1:0]          cfg_wdata_i,
  // input items
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // opcode[1:0], dot_x[8:2], dot_y[12:9], slot_index[18:13], byte_address[26:19]
  input  logic [sdtpr_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // result items
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // status[1:0], page_byte[9:2]
  output logic [sdtpr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int unsigned CW = $clog2(MAX_DOTS + 1);

  sdtpr_pkg::state_e                state_q, state_d;
  sdtpr_pkg::op_e                   op_q;
  logic [sdtpr_pkg::X_W-1:0]        x_q;
  logic [sdtpr_pkg::Y_W-1:0]        y_q;
  logic [sdtpr_pkg::SLOT_W-1:0]     slot_q;
  logic [sdtpr_pkg::ADDR_W-1:0]     baddr_q;
  logic [sdtpr_pkg::CFG_W-1:0]      active_q;
  logic [CW-1:0]                    filled_q, filled_d;
  logic [CW-1:0]                    ph_q, ph_d;
  logic                             par_q, par_d;
  logic [MAX_DOTS-1:0]              eq_q, gt_q, hit_q;
  sdtpr_pkg::status_e               res_status_q, res_status_d;
  logic [sdtpr_pkg::BYTE_W-1:0]     res_byte_q, res_byte_d;
  logic                             out_valid_q, out_valid_d;
  sdtpr_pkg::status_e               out_status_q;
  logic [sdtpr_pkg::BYTE_W-1:0]     out_byte_q;
  logic                             out_load;

  logic [CW-1:0]                    n;
  logic [6:0]                       slot_ext, nm1, slot_sel;
  logic [MAX_DOTS-1:0]              below_filled, upto_filled, below_n, at_slot;
  logic [MAX_DOTS-1:0]              gtm, low, ge, first, swap, swap_left;
  logic                             dup_app, dup_rep, full, empty;
  logic [sdtpr_pkg::BYTE_W-1:0]     rd_byte;
  logic                             in_acc;

  sdtpr_pkg::bcast_t                bcast;
  sdtpr_pkg::cell_op_e              cell_op  [MAX_DOTS];
  sdtpr_pkg::cell_out_t             outs     [MAX_DOTS];
  sdtpr_pkg::cell_out_t             left_in  [MAX_DOTS];
  sdtpr_pkg::cell_out_t             right_in [MAX_DOTS];

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == sdtpr_pkg::S_IDLE);

  // operands broadcast to the cells
  always_comb begin
    bcast.x        = x_q;
    bcast.y        = y_q;
    bcast.new_addr = sdtpr_pkg::dot_addr(x_q, y_q, sdtpr_pkg::ADDR_W'(COLUMNS));
    bcast.baddr    = baddr_q;
  end

  // row of cells, each linked to both neighbors
  for (genvar g = 0; g < MAX_DOTS; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left_in[g] = '0;
    end else begin : g_mid_l
      assign left_in[g] = outs[g-1];
    end
    if (g == MAX_DOTS - 1) begin : g_last
      assign right_in[g] = '0;
    end else begin : g_mid_r
      assign right_in[g] = outs[g+1];
    end
    sdtpr_cell #(
      .COLUMNS (COLUMNS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (cell_op[g]),
      .bcast_i (bcast),
      .left_i  (left_in[g]),
      .right_i (right_in[g]),
      .cell_o  (outs[g])
    );
  end

  // active count and clamped replace slot
  always_comb begin
    n = ({1'b0, active_q} >= 7'(MAX_DOTS)) ? CW'(MAX_DOTS) : CW'(active_q);
    slot_ext = 7'(slot_q);
    nm1      = 7'(n) - 7'd1;
    slot_sel = (slot_ext > nm1) ? nm1 : slot_ext;
  end

  // per-slot position masks
  always_comb begin
    for (int i = 0; i < MAX_DOTS; i++) begin
      below_filled[i] = CW'(i) < filled_q;
      upto_filled[i]  = CW'(i) <= filled_q;
      below_n[i]      = CW'(i) < n;
      at_slot[i]      = 7'(i) == slot_sel;
    end
  end

  // insert position: first filled slot with a greater address, else the fill end
  always_comb begin
    gtm   = gt_q & below_filled;
    low   = gtm & (~gtm + MAX_DOTS'(1));
    ge    = (gtm != '0) ? ~(low - MAX_DOTS'(1)) : ~below_filled;
    first = ge & ~(ge << 1);
  end

  // sort phase: swap strictly out of order pairs inside the active part
  always_comb begin
    for (int i = 0; i < MAX_DOTS; i++) begin
      swap[i] = (1'(i) == par_q) && (CW'(i + 1) < n) && outs[i].gt_right;
    end
    swap_left = swap << 1;
  end

  // table decisions and rendered byte
  always_comb begin
    dup_app = |(eq_q & below_filled);
    dup_rep = |(eq_q & below_n);
    full    = filled_q >= CW'(MAX_DOTS);
    empty   = n == '0;
    rd_byte = '0;
    for (int i = 0; i < MAX_DOTS; i++) begin
      if (hit_q[i] && below_n[i]) begin
        rd_byte = rd_byte | (sdtpr_pkg::BYTE_W'(1) << outs[i].y[2:0]);
      end
    end
  end

  // cell commands
  always_comb begin
    for (int i = 0; i < MAX_DOTS; i++) begin
      cell_op[i] = sdtpr_pkg::CELL_HOLD;
      case (state_q)
        sdtpr_pkg::S_EVAL: begin
          if (op_q == sdtpr_pkg::OP_CLEAR) cell_op[i] = sdtpr_pkg::CELL_CLEAR;
        end
        sdtpr_pkg::S_DECIDE: begin
          if (op_q == sdtpr_pkg::OP_APPEND && !dup_app && !full) begin
            if (first[i]) cell_op[i] = sdtpr_pkg::CELL_LOAD;
            else if (ge[i] && upto_filled[i]) cell_op[i] = sdtpr_pkg::CELL_FROM_LEFT;
          end else if (op_q == sdtpr_pkg::OP_REPLACE && !empty && !dup_rep) begin
            if (at_slot[i]) cell_op[i] = sdtpr_pkg::CELL_LOAD;
          end
        end
        sdtpr_pkg::S_SORT: begin
          if (swap[i]) cell_op[i] = sdtpr_pkg::CELL_FROM_RIGHT;
          else if (swap_left[i]) cell_op[i] = sdtpr_pkg::CELL_FROM_LEFT;
        end
        default: ;
      endcase
    end
  end

  // state machine: next state and result
  always_comb begin
    state_d      = state_q;
    filled_d     = filled_q;
    ph_d         = ph_q;
    par_d        = par_q;
    res_status_d = res_status_q;
    res_byte_d   = res_byte_q;
    out_valid_d  = out_valid_q && !m_axis_tready;
    out_load     = 1'b0;
    case (state_q)
      sdtpr_pkg::S_IDLE: begin
        if (s_axis_tvalid) state_d = sdtpr_pkg::S_EVAL;
      end
      sdtpr_pkg::S_EVAL: begin
        if (op_q == sdtpr_pkg::OP_CLEAR) begin
          filled_d     = '0;
          res_status_d = sdtpr_pkg::ST_DONE;
          res_byte_d   = '0;
          state_d      = sdtpr_pkg::S_OUT;
        end else begin
          state_d = sdtpr_pkg::S_DECIDE;
        end
      end
      sdtpr_pkg::S_DECIDE: begin
        res_byte_d   = '0;
        res_status_d = sdtpr_pkg::ST_DONE;
        state_d      = sdtpr_pkg::S_OUT;
        case (op_q)
          sdtpr_pkg::OP_APPEND: begin
            if (dup_app) res_status_d = sdtpr_pkg::ST_DUP;
            else if (full) res_status_d = sdtpr_pkg::ST_FULL;
            else filled_d = filled_q + CW'(1);
          end
          sdtpr_pkg::OP_REPLACE: begin
            if (empty) res_status_d = sdtpr_pkg::ST_EMPTY;
            else if (dup_rep) res_status_d = sdtpr_pkg::ST_DUP;
            else begin
              ph_d    = '0;
              par_d   = 1'b0;
              state_d = sdtpr_pkg::S_SORT;
            end
          end
          sdtpr_pkg::OP_READ: begin
            res_byte_d = rd_byte;
          end
          default: ;
        endcase
      end
      sdtpr_pkg::S_SORT: begin
        par_d = ~par_q;
        ph_d  = ph_q + CW'(1);
        if (ph_q == n - CW'(1)) state_d = sdtpr_pkg::S_OUT;
      end
      sdtpr_pkg::S_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = sdtpr_pkg::S_IDLE;
        end
      end
      default: state_d = sdtpr_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdtpr_pkg::S_IDLE;
      filled_q    <= '0;
      active_q    <= '0;
      ph_q        <= '0;
      par_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      filled_q    <= filled_d;
      ph_q        <= ph_d;
      par_q       <= par_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) active_q <= cfg_wdata_i;
    end
  end

  // item operands, compare flags and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q    <= sdtpr_pkg::op_e'(s_axis_tdata[1:0]);
      x_q     <= s_axis_tdata[8:2];
      y_q     <= s_axis_tdata[12:9];
      slot_q  <= s_axis_tdata[18:13];
      baddr_q <= s_axis_tdata[26:19];
    end
    if (state_q == sdtpr_pkg::S_EVAL) begin
      for (int i = 0; i < MAX_DOTS; i++) begin
        eq_q[i]  <= outs[i].eq;
        gt_q[i]  <= outs[i].gt_new;
        hit_q[i] <= outs[i].hit;
      end
    end
    res_status_q <= res_status_d;
    res_byte_q   <= res_byte_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_byte_q   <= res_byte_q;
    end
  end

  // result port
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    {(sdtpr_pkg::OUT_TDATA_W - sdtpr_pkg::STATUS_W - sdtpr_pkg::BYTE_W){1'b0}},
    out_byte_q, out_status_q
  };

endmodule

// File: sv/sdtpr_checker.sv
// ----------------------------------------------------------------------------
// sdtpr_checker
// port level checks of the sorted dot table renderer, bound to the top level
// ----------------------------------------------------------------------------
`include "sorted_dot_table_page_renderer_core_assert.svh"

module sdtpr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               s_axis_tvalid,
  input logic                               s_axis_tready,
  input logic                               m_axis_tvalid,
  input logic                               m_axis_tready,
  input logic [sdtpr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

  // a stalled result holds
  `SDTPR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // one item at a time: an accepted item closes the input
  `SDTPR_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // refused items carry no page byte
  `SDTPR_ASSERT_SAME(a_status_no_byte, clk_i, rst_ni, m_axis_tvalid && (m_axis_tdata[1:0] != sdtpr_pkg::ST_DONE), m_axis_tdata[9:2] == 8'd0)

  // padding bits of a result stay zero
  `SDTPR_ASSERT_SAME(a_out_pad_zero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[15:10] == 6'd0)

endmodule

bind sorted_dot_table_page_renderer_core sdtpr_checker u_sdtpr_checker (.*);
